[hdl/u8w_pkg.sv]
// ----------------------------------------------------------------------------
// u8w_pkg: shared types, constants and width tables
// Holds the queue entry layout and the display-width range tables used by
// the UTF-8 decoder with column width.
// ----------------------------------------------------------------------------
package u8w_pkg;

  localparam int COUNT_BITS = 16;
  localparam int CP_W       = 21;
  localparam int LEN_W      = 3;
  localparam int COLS_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CP      = 2'd1;

  localparam logic [CP_W-1:0] RESET_REPLACEMENT = 21'h00FFFD;
  localparam logic [CP_W-1:0] RESET_MAX_CP      = 21'h10FFFF;

  // Column widths
  localparam logic [COLS_W-1:0] COLS_ZERO   = 2'd0;
  localparam logic [COLS_W-1:0] COLS_NARROW = 2'd1;
  localparam logic [COLS_W-1:0] COLS_WIDE   = 2'd2;

  // One decoded input byte: rejections first, then a code point, then a summary
  typedef struct packed {
    logic [LEN_W-1:0]      rej_cnt;
    logic                  has_cp;
    logic [CP_W-1:0]       cp;
    logic [LEN_W-1:0]      cp_len;
    logic                  has_sum;
    logic [COUNT_BITS-1:0] bad_pos;
  } entry_t;

  typedef struct packed {
    logic [CP_W-1:0] lo;
    logic [CP_W-1:0] hi;
  } span_t;

  localparam int ZERO_N = 31;
  localparam int WIDE_N = 15;

  localparam span_t ZERO_TAB [ZERO_N] = '{
    '{21'h000AD, 21'h000AD}, '{21'h00300, 21'h0036F}, '{21'h00483, 21'h00489},
    '{21'h00591, 21'h005BD}, '{21'h005BF, 21'h005BF}, '{21'h005C1, 21'h005C2},
    '{21'h005C4, 21'h005C5}, '{21'h005C7, 21'h005C7}, '{21'h00610, 21'h0061A},
    '{21'h0064B, 21'h0065F}, '{21'h00670, 21'h00670}, '{21'h00E31, 21'h00E31},
    '{21'h00E34, 21'h00E3A}, '{21'h00E47, 21'h00E4E}, '{21'h01160, 21'h011FF},
    '{21'h0135D, 21'h0135F}, '{21'h01AB0, 21'h01AFF}, '{21'h01DC0, 21'h01DFF},
    '{21'h0200B, 21'h0200F}, '{21'h02028, 21'h0202E}, '{21'h02060, 21'h02064},
    '{21'h0206A, 21'h0206F}, '{21'h020D0, 21'h020FF}, '{21'h03099, 21'h0309A},
    '{21'h0FE00, 21'h0FE0F}, '{21'h0FE20, 21'h0FE2F}, '{21'h0FEFF, 21'h0FEFF},
    '{21'h0FFF9, 21'h0FFFB}, '{21'hE0001, 21'hE0001}, '{21'hE0020, 21'hE007F},
    '{21'hE0100, 21'hE01EF}
  };

  localparam span_t WIDE_TAB [WIDE_N] = '{
    '{21'h01100, 21'h0115F}, '{21'h02E80, 21'h0303E}, '{21'h03041, 21'h033FF},
    '{21'h03400, 21'h04DBF}, '{21'h04E00, 21'h09FFF}, '{21'h0A000, 21'h0A4CF},
    '{21'h0AC00, 21'h0D7A3}, '{21'h0F900, 21'h0FAFF}, '{21'h0FE10, 21'h0FE19},
    '{21'h0FE30, 21'h0FE6F}, '{21'h0FF00, 21'h0FF60}, '{21'h0FFE0, 21'h0FFE6},
    '{21'h1F300, 21'h1F64F}, '{21'h1F900, 21'h1F9FF}, '{21'h20000, 21'h3FFFD}
  };

  localparam logic [CP_W-1:0] NARROW_LIMIT = 21'h000AD;

  // Spans are sorted and disjoint, so membership is an OR of range hits
  function automatic logic [COLS_W-1:0] cp_columns(input logic [CP_W-1:0] cp);
    logic zero_hit;
    logic wide_hit;
    zero_hit = 1'b0;
    wide_hit = 1'b0;
    for (int i = 0; i < ZERO_N; i++) begin
      if (cp >= ZERO_TAB[i].lo && cp <= ZERO_TAB[i].hi) zero_hit = 1'b1;
    end
    for (int i = 0; i < WIDE_N; i++) begin
      if (cp >= WIDE_TAB[i].lo && cp <= WIDE_TAB[i].hi) wide_hit = 1'b1;
    end
    if (cp < NARROW_LIMIT) return COLS_NARROW;
    else if (zero_hit) return COLS_ZERO;
    else if (wide_hit) return COLS_WIDE;
    else return COLS_NARROW;
  endfunction

endpackage

[hdl/u8w_front.sv]
// ----------------------------------------------------------------------------
// u8w_front: byte intake and sequence classification
// Tracks the pending multi-byte sequence and turns each accepted byte that
// causes results into one queue entry describing them.
// ----------------------------------------------------------------------------
module u8w_front import u8w_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,
  input  logic [7:0]            in_byte,
  input  logic [CP_W-1:0]       max_cp,
  output logic                  push,
  output entry_t                ent
);

  localparam logic [LEN_W-1:0] LEN_NONE  = 3'd0;
  localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
  localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
  localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
  localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

  localparam logic [CP_W-1:0] MIN_TWO   = 21'h00080;
  localparam logic [CP_W-1:0] MIN_THREE = 21'h00800;
  localparam logic [CP_W-1:0] MIN_FOUR  = 21'h10000;
  localparam logic [CP_W-1:0] SURR_LO   = 21'h0D800;
  localparam logic [CP_W-1:0] SURR_HI   = 21'h0DFFF;

  logic [LEN_W-1:0]      exp_r,  exp_nxt;
  logic [LEN_W-1:0]      seen_r, seen_nxt;
  logic [CP_W-1:0]       part_r, part_nxt;
  logic [COUNT_BITS-1:0] pos_r,  pos_nxt;
  logic [COUNT_BITS-1:0] lead_r, lead_nxt;

  logic                  pending;
  logic                  is_cont;
  logic [CP_W-1:0]       pv;
  logic [LEN_W-1:0]      seen_inc;
  logic [CP_W-1:0]       min_v;
  logic                  seq_bad;
  logic [COUNT_BITS-1:0] pos_adv;

  assign pending  = (exp_r != LEN_NONE);
  assign is_cont  = (in_byte[7:6] == 2'b10);
  assign pv       = {part_r[CP_W-7:0], in_byte[5:0]};
  assign seen_inc = seen_r + LEN_ONE;
  assign pos_adv  = (pos_r != COUNT_MAX) ? pos_r + 1'b1 : pos_r;

  always_comb begin
    case (exp_r)
      LEN_TWO:   min_v = MIN_TWO;
      LEN_THREE: min_v = MIN_THREE;
      LEN_FOUR:  min_v = MIN_FOUR;
      default:   min_v = '0;
    endcase
  end

  assign seq_bad = (pv < min_v) || (pv >= SURR_LO && pv <= SURR_HI) || (pv > max_cp);

  always_comb begin
    exp_nxt  = exp_r;
    seen_nxt = seen_r;
    part_nxt = part_r;
    pos_nxt  = pos_r;
    lead_nxt = lead_r;
    ent      = '0;
    ent.bad_pos = lead_r;
    if (take) begin
      if (pending && is_cont) begin
        // continuation: fold in six bits, close the sequence when complete
        pos_nxt = pos_adv;
        if (seen_inc >= exp_r) begin
          if (seq_bad) begin
            ent.rej_cnt = seen_inc;
          end else begin
            ent.has_cp = 1'b1;
            ent.cp     = pv;
            ent.cp_len = exp_r;
          end
          exp_nxt  = LEN_NONE;
          seen_nxt = LEN_NONE;
          part_nxt = '0;
        end else begin
          part_nxt = pv;
          seen_nxt = seen_inc;
        end
      end else begin
        // drop a broken sequence, then decode this byte afresh
        if (pending) begin
          ent.rej_cnt = seen_r;
          exp_nxt  = LEN_NONE;
          seen_nxt = LEN_NONE;
          part_nxt = '0;
        end
        if (in_byte == 8'h00) begin
          ent.has_sum = 1'b1;
          pos_nxt     = '0;
          lead_nxt    = '0;
        end else begin
          pos_nxt = pos_adv;
          if (in_byte[7] == 1'b0) begin
            ent.has_cp = 1'b1;
            ent.cp     = {{(CP_W-8){1'b0}}, in_byte};
            ent.cp_len = LEN_ONE;
          end else if (in_byte[7:5] == 3'b110) begin
            exp_nxt  = LEN_TWO;
            seen_nxt = LEN_ONE;
            part_nxt = {{(CP_W-5){1'b0}}, in_byte[4:0]};
            lead_nxt = pos_r;
          end else if (in_byte[7:4] == 4'b1110) begin
            exp_nxt  = LEN_THREE;
            seen_nxt = LEN_ONE;
            part_nxt = {{(CP_W-4){1'b0}}, in_byte[3:0]};
            lead_nxt = pos_r;
          end else if (in_byte[7:3] == 5'b11110) begin
            exp_nxt  = LEN_FOUR;
            seen_nxt = LEN_ONE;
            part_nxt = {{(CP_W-3){1'b0}}, in_byte[2:0]};
            lead_nxt = pos_r;
          end else begin
            if (!pending) ent.bad_pos = pos_r;
            ent.rej_cnt = ent.rej_cnt + LEN_ONE;
          end
        end
      end
    end
  end

  assign push = take && ((ent.rej_cnt != LEN_NONE) || ent.has_cp || ent.has_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r  <= LEN_NONE;
      seen_r <= LEN_NONE;
      part_r <= '0;
      pos_r  <= '0;
      lead_r <= '0;
    end else begin
      exp_r  <= exp_nxt;
      seen_r <= seen_nxt;
      part_r <= part_nxt;
      pos_r  <= pos_nxt;
      lead_r <= lead_nxt;
    end
  end

endmodule

[hdl/u8w_queue.sv]
// ----------------------------------------------------------------------------
// u8w_queue: entry queue between front and back
// Small first-in first-out buffer of decoded entries.
// ----------------------------------------------------------------------------
module u8w_queue import u8w_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t wr_ent,
  input  logic   pop,
  output entry_t head,
  output logic   not_empty,
  output logic   full
);

  entry_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r,    cnt_nxt;
  logic                do_push;
  logic                do_pop;

  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[hdl/u8w_back.sv]
// ----------------------------------------------------------------------------
// u8w_back: result sequencer
// Expands each queue entry into its results, one per cycle unless stalled,
// looks up the column width and keeps the per-string totals for the summary.
// ----------------------------------------------------------------------------
module u8w_back import u8w_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  entry_t                head,
  output logic                  pop,
  input  logic [CP_W-1:0]       rep_cp,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_is_summary,
  output logic [CP_W-1:0]       out_code_point,
  output logic [LEN_W-1:0]      out_byte_count,
  output logic                  out_rejected,
  output logic [COLS_W-1:0]     out_columns,
  output logic [COUNT_BITS-1:0] out_total_columns,
  output logic                  out_all_valid,
  output logic [COUNT_BITS-1:0] out_first_bad_offset,
  output logic                  out_last_of_run
);

  logic                  vld_r,  vld_nxt;
  logic [1:0]            idx_r,  idx_nxt;
  logic [COUNT_BITS-1:0] sum_r,  sum_nxt;
  logic                  bad_r,  bad_nxt;
  logic [COUNT_BITS-1:0] badp_r, badp_nxt;

  logic                  summ_r;
  logic [CP_W-1:0]       cp_r;
  logic [LEN_W-1:0]      cnt_r;
  logic                  rej_r;
  logic [COLS_W-1:0]     cols_r;
  logic [COUNT_BITS-1:0] tot_r;
  logic                  ok_r;
  logic [COUNT_BITS-1:0] off_r;
  logic                  last_r;

  logic                  load;
  logic [LEN_W-1:0]      idx_ext;
  logic [LEN_W-1:0]      total;
  logic                  is_rej;
  logic                  is_cp;
  logic                  is_last;
  logic [CP_W-1:0]       sel_cp;
  logic [COLS_W-1:0]     cols;
  logic [COUNT_BITS:0]   sum_add;

  assign load    = q_valid && (!vld_r || !out_stall);
  assign idx_ext = {1'b0, idx_r};
  assign total   = head.rej_cnt + LEN_W'(head.has_cp) + LEN_W'(head.has_sum);
  assign is_rej  = (idx_ext < head.rej_cnt);
  assign is_cp   = !is_rej && head.has_cp && (idx_ext == head.rej_cnt);
  assign is_last = ((idx_ext + 1'b1) == total);
  assign sel_cp  = is_rej ? rep_cp : head.cp;
  assign cols    = cp_columns(sel_cp);
  assign sum_add = {1'b0, sum_r} + {{(COUNT_BITS-1){1'b0}}, cols};
  assign pop     = load && is_last;

  always_comb begin
    vld_nxt  = vld_r;
    idx_nxt  = idx_r;
    sum_nxt  = sum_r;
    bad_nxt  = bad_r;
    badp_nxt = badp_r;
    if (load) begin
      vld_nxt = 1'b1;
      idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;
      if (is_rej || is_cp) begin
        // saturate the running column total
        sum_nxt = sum_add[COUNT_BITS] ? COUNT_MAX : sum_add[COUNT_BITS-1:0];
        if (is_rej && !bad_r) begin
          bad_nxt  = 1'b1;
          badp_nxt = head.bad_pos;
        end
      end else begin
        sum_nxt  = '0;
        bad_nxt  = 1'b0;
        badp_nxt = '0;
      end
    end else if (vld_r && !out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      idx_r  <= 2'd0;
      sum_r  <= '0;
      bad_r  <= 1'b0;
      badp_r <= '0;
    end else begin
      vld_r  <= vld_nxt;
      idx_r  <= idx_nxt;
      sum_r  <= sum_nxt;
      bad_r  <= bad_nxt;
      badp_r <= badp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      last_r <= is_last;
      if (is_rej || is_cp) begin
        summ_r <= 1'b0;
        cp_r   <= sel_cp;
        cnt_r  <= is_rej ? 3'd1 : head.cp_len;
        rej_r  <= is_rej;
        cols_r <= cols;
        tot_r  <= '0;
        ok_r   <= 1'b0;
        off_r  <= '0;
      end else begin
        summ_r <= 1'b1;
        cp_r   <= '0;
        cnt_r  <= '0;
        rej_r  <= 1'b0;
        cols_r <= COLS_ZERO;
        tot_r  <= sum_r;
        ok_r   <= !bad_r;
        off_r  <= bad_r ? badp_r : '0;
      end
    end
  end

  assign out_valid            = vld_r;
  assign out_is_summary       = summ_r;
  assign out_code_point       = cp_r;
  assign out_byte_count       = cnt_r;
  assign out_rejected         = rej_r;
  assign out_columns          = cols_r;
  assign out_total_columns    = tot_r;
  assign out_all_valid        = ok_r;
  assign out_first_bad_offset = off_r;
  assign out_last_of_run      = last_r;

endmodule

[hdl/utf8_stream_decoder_width_unit.sv]
// ----------------------------------------------------------------------------
// utf8_stream_decoder_width_unit: UTF-8 decoder with display column width
// Decodes a NUL-terminated byte stream, replaces rejected bytes, classifies
// each code point as 0, 1 or 2 columns and ends each string with a summary.
// ----------------------------------------------------------------------------
//
//  channel  | signals                               | direction | request
//  ---------+---------------------------------------+-----------+---------------------
//  in       | in_valid, in_stall, in_byte           | input     | one string byte
//  out      | out_valid, out_stall, out_* fields    | output    | code point / summary
//  cfg      | cfg_valid, cfg_ready, cfg_index/data  | input     | register write
//
//  A byte is taken every cycle while the entry queue has room; the front
//  decodes it in that cycle and queues an entry when it causes results.
//  The back emits one result per cycle while out_stall is low; the result
//  register sets that rate on the output side.
//  The first result of a byte passes through the queue and then the result register.
//  Reset (synchronous, rst_n low) clears the pending sequence, counters,
//  queue and output valid, and loads the register defaults.
//  in_stall rises only when the four-entry queue is full; out_stall holds
//  the result register and, through the queue, eventually the input.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_width_unit import u8w_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // byte input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_byte,
  // results
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_is_summary,
  output logic [CP_W-1:0]       out_code_point,
  output logic [LEN_W-1:0]      out_byte_count,
  output logic                  out_rejected,
  output logic [COLS_W-1:0]     out_columns,
  output logic [COUNT_BITS-1:0] out_total_columns,
  output logic                  out_all_valid,
  output logic [COUNT_BITS-1:0] out_first_bad_offset,
  output logic                  out_last_of_run,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CP_W-1:0]       cfg_data
);

  logic [CP_W-1:0] rep_cp_r, rep_cp_nxt;
  logic [CP_W-1:0] max_cp_r, max_cp_nxt;

  logic   take;
  logic   push;
  entry_t fr_ent;
  entry_t q_head;
  logic   q_valid;
  logic   q_full;
  logic   pop;

  // Configuration registers: writes always complete, unknown indexes drop
  assign cfg_ready = 1'b1;

  always_comb begin
    rep_cp_nxt = rep_cp_r;
    max_cp_nxt = max_cp_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_REPLACEMENT: rep_cp_nxt = cfg_data;
        REG_MAX_CP:      max_cp_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_cp_r <= RESET_REPLACEMENT;
      max_cp_r <= RESET_MAX_CP;
    end else begin
      rep_cp_r <= rep_cp_nxt;
      max_cp_r <= max_cp_nxt;
    end
  end

  // Hold the input only while the queue cannot take another entry
  assign in_stall = q_full;
  assign take     = in_valid && !in_stall;

  u8w_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .in_byte (in_byte),
    .max_cp  (max_cp_r),
    .push    (push),
    .ent     (fr_ent)
  );

  u8w_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_ent    (fr_ent),
    .pop       (pop),
    .head      (q_head),
    .not_empty (q_valid),
    .full      (q_full)
  );

  u8w_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_valid              (q_valid),
    .head                 (q_head),
    .pop                  (pop),
    .rep_cp               (rep_cp_r),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_is_summary       (out_is_summary),
    .out_code_point       (out_code_point),
    .out_byte_count       (out_byte_count),
    .out_rejected         (out_rejected),
    .out_columns          (out_columns),
    .out_total_columns    (out_total_columns),
    .out_all_valid        (out_all_valid),
    .out_first_bad_offset (out_first_bad_offset),
    .out_last_of_run      (out_last_of_run)
  );

endmodule
